/* rtl/cttk_pkg.sv */
// Shared types and constants for the configuration text tokenizer.
`default_nettype none

package cttk_pkg;

    localparam int FIFO_DEPTH_DEF = 4;
    localparam int MAX_EVENTS     = 4;

    localparam logic [3:0]  TAB_RESET = 4'd8;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;

    // Event codes
    localparam logic [2:0] EV_OPEN    = 3'd0;
    localparam logic [2:0] EV_BYTE    = 3'd1;
    localparam logic [2:0] EV_CLOSE   = 3'd2;
    localparam logic [2:0] EV_SPECIAL = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;
    localparam logic [2:0] EV_WARN    = 3'd5;
    localparam logic [2:0] EV_FATAL   = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_STRING    = 2'd1;
    localparam logic [1:0] ERR_BLOCK     = 2'd2;
    localparam logic [1:0] ERR_STRAY_END = 2'd3;

    typedef struct packed {
        logic [2:0] code;
        logic [7:0] tbyte;
        logic [1:0] err;
    } t_evt;

    // All events caused by one byte, with the position after that byte
    typedef struct packed {
        logic [2:0]            cnt;
        t_evt [MAX_EVENTS-1:0] ev;
        logic [15:0]           line;
        logic [15:0]           col;
    } t_bundle;

    // Queue status seen by the back end
    typedef struct packed {
        logic    empty;
        logic    full;
        t_bundle head;
    } t_q_status;

endpackage

`default_nettype wire

/* rtl/config_text_tokenizer_core.sv */
// Path: an accepted byte's bundle is written into the bundle queue and then loaded
//   into the back end's bundle register, from which its results are shown.
// Throughput: one byte per cycle is taken while the bundle queue has room; results
//   leave at one per cycle while the output is not stalled.
// Bytes that give no result (whitespace, comments) never touch the queue.
// Reset: synchronous, active low; lexer state, position, tab width and queue clear.
`default_nettype none

module config_text_tokenizer_core #(
    parameter int FIFO_DEPTH = cttk_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_byte_req,
    input  wire logic        i_end_of_input,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [2:0]  o_event_res,
    output      logic [7:0]  o_token_byte,
    output      logic [1:0]  o_error_code,
    output      logic [15:0] o_line_number,
    output      logic [15:0] o_column_number,
    output      logic        o_last
);
    import cttk_pkg::*;

    logic      push, pop;
    t_bundle   bundle;
    t_q_status qs;

    assign o_in_stall = qs.full;

    cttk_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_q_full       (qs.full),
        .i_byte_req     (i_byte_req),
        .i_end_of_input (i_end_of_input),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_bundle       (bundle)
    );

    cttk_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (bundle),
        .i_pop    (pop),
        .o_status (qs)
    );

    cttk_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q             (qs),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_token_byte    (o_token_byte),
        .o_error_code    (o_error_code),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last          (o_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qs.full) else $error("bundle pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qs.empty) else $error("bundle popped from empty queue");

    a_fatal_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_FATAL)) |-> o_last)
        else $error("fatal event not last of its byte");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_END)) |-> o_last)
        else $error("end event not last of its byte");

    a_last_holds_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && o_last) |=> (o_out_valid && o_last))
        else $error("final beat lost under stall");

endmodule

`default_nettype wire

/* rtl/cttk_front.sv */
// Front end: accepts text bytes, runs the lexer state and forms event bundles.
`default_nettype none

module cttk_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_q_full,
    input  wire logic [7:0]        i_byte_req,
    input  wire logic              i_end_of_input,
    input  wire logic              i_cfg_we,
    input  wire logic [3:0]        i_cfg_data,
    output      logic              o_push,
    output      cttk_pkg::t_bundle o_bundle
);
    import cttk_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [7:0] {
        ST_SKIP   = 8'b0000_0001,
        ST_SLASH  = 8'b0000_0010,
        ST_LINE   = 8'b0000_0100,
        ST_BLOCK  = 8'b0000_1000,
        ST_STRING = 8'b0001_0000,
        ST_STRESC = 8'b0010_0000,
        ST_BARE   = 8'b0100_0000,
        ST_HALT   = 8'b1000_0000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic        r_star, n_star;
    logic [15:0] r_line, n_line;
    logic [15:0] r_col,  n_col;
    logic [3:0]  r_tab;

    logic        accept;
    logic        is_ws, is_spec;
    logic [16:0] col_sum;
    logic [15:0] col_add;
    t_evt [MAX_EVENTS-1:0] ev;
    logic [2:0]  idx;
    logic        run_bare, run_bt;

    function automatic t_evt mk(input logic [2:0] code, input logic [7:0] b,
                                input logic [1:0] err);
        t_evt e;
        e.code  = code;
        e.tbyte = b;
        e.err   = err;
        return e;
    endfunction

    assign accept = i_in_valid && !i_q_full;

    assign is_ws = (i_byte_req == CH_SPACE) ||
                   ((i_byte_req >= CH_TAB) && (i_byte_req <= 8'h0D));
    assign is_spec = (i_byte_req == 8'h3A) || (i_byte_req == 8'h7B) ||
                     (i_byte_req == 8'h7D) || (i_byte_req == 8'h5B) ||
                     (i_byte_req == 8'h5D) || (i_byte_req == 8'h2C) ||
                     (i_byte_req == 8'h3D) || (i_byte_req == CH_BSLASH);

    // Position after this byte
    assign col_add = (i_byte_req == CH_TAB) ? {12'd0, r_tab} : 16'd1;
    assign col_sum = {1'b0, r_col} + {1'b0, col_add};

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (!i_end_of_input) begin
            if (i_byte_req == CH_LF) begin
                n_col = 16'd1;
                if (r_line != POS_MAX) n_line = r_line + 16'd1;
            end else begin
                n_col = col_sum[16] ? POS_MAX : col_sum[15:0];
            end
        end
    end

    // Lexer step: up to four events in order
    always_comb begin
        n_mode   = r_mode;
        n_star   = r_star;
        ev       = '0;
        idx      = 3'd0;
        run_bare = 1'b0;
        run_bt   = 1'b0;
        if (i_end_of_input) begin
            unique case (r_mode)
                ST_BLOCK: begin
                    ev[idx[1:0]] = mk(EV_FATAL, 8'd0, ERR_BLOCK); idx = idx + 3'd1;
                    n_mode = ST_HALT;
                    n_star = 1'b0;
                end
                ST_STRING, ST_STRESC: begin
                    ev[idx[1:0]] = mk(EV_FATAL, 8'd0, ERR_STRING); idx = idx + 3'd1;
                    n_mode = ST_HALT;
                    n_star = 1'b0;
                end
                ST_BARE: begin
                    ev[idx[1:0]] = mk(EV_CLOSE, 8'd0, ERR_NONE); idx = idx + 3'd1;
                    ev[idx[1:0]] = mk(EV_END, 8'd0, ERR_NONE);   idx = idx + 3'd1;
                    n_mode = ST_SKIP;
                    n_star = 1'b0;
                end
                ST_HALT: begin
                end
                default: begin
                    ev[idx[1:0]] = mk(EV_END, 8'd0, ERR_NONE); idx = idx + 3'd1;
                    n_mode = ST_SKIP;
                    n_star = 1'b0;
                end
            endcase
        end else begin
            unique case (r_mode)
                ST_SLASH: begin
                    if (i_byte_req == CH_SLASH) begin
                        n_mode = ST_LINE;
                    end else if (i_byte_req == CH_STAR) begin
                        n_mode = ST_BLOCK;
                        n_star = 1'b0;
                    end else begin
                        // held slash opens a bare name
                        ev[idx[1:0]] = mk(EV_OPEN, 8'd0, ERR_NONE);     idx = idx + 3'd1;
                        ev[idx[1:0]] = mk(EV_BYTE, CH_SLASH, ERR_NONE); idx = idx + 3'd1;
                        run_bare = 1'b1;
                    end
                end
                ST_LINE: begin
                    if (i_byte_req == CH_LF) n_mode = ST_SKIP;
                end
                ST_BLOCK: begin
                    if (r_star && (i_byte_req == CH_SLASH)) begin
                        n_mode = ST_SKIP;
                        n_star = 1'b0;
                    end else begin
                        n_star = (i_byte_req == CH_STAR);
                    end
                end
                ST_STRING: begin
                    if (i_byte_req == CH_BSLASH) begin
                        n_mode = ST_STRESC;
                    end else if (i_byte_req == CH_QUOTE) begin
                        ev[idx[1:0]] = mk(EV_CLOSE, 8'd0, ERR_NONE); idx = idx + 3'd1;
                        n_mode = ST_SKIP;
                    end else begin
                        ev[idx[1:0]] = mk(EV_BYTE, i_byte_req, ERR_NONE); idx = idx + 3'd1;
                    end
                end
                ST_STRESC: begin
                    if (i_byte_req != CH_QUOTE) begin
                        ev[idx[1:0]] = mk(EV_WARN, i_byte_req, ERR_NONE); idx = idx + 3'd1;
                    end
                    ev[idx[1:0]] = mk(EV_BYTE, i_byte_req, ERR_NONE); idx = idx + 3'd1;
                    n_mode = ST_STRING;
                end
                ST_BARE: begin
                    run_bare = 1'b1;
                end
                ST_HALT: begin
                end
                default: begin
                    run_bt = 1'b1;
                end
            endcase

            if (run_bare) begin
                if (is_spec || is_ws) begin
                    ev[idx[1:0]] = mk(EV_CLOSE, 8'd0, ERR_NONE); idx = idx + 3'd1;
                    n_star = 1'b0;
                    run_bt = 1'b1;
                end else begin
                    ev[idx[1:0]] = mk(EV_BYTE, i_byte_req, ERR_NONE); idx = idx + 3'd1;
                    n_mode = ST_BARE;
                end
            end

            if (run_bt) begin
                n_mode = ST_SKIP;
                if (is_ws) begin
                    n_star = 1'b0;
                end else if (i_byte_req == CH_SLASH) begin
                    if (n_star) begin
                        ev[idx[1:0]] = mk(EV_FATAL, 8'd0, ERR_STRAY_END); idx = idx + 3'd1;
                        n_mode = ST_HALT;
                        n_star = 1'b0;
                    end else begin
                        n_mode = ST_SLASH;
                    end
                end else if (i_byte_req == CH_STAR) begin
                    n_star = 1'b1;
                end else begin
                    n_star = 1'b0;
                    if (is_spec) begin
                        ev[idx[1:0]] = mk(EV_SPECIAL, i_byte_req, ERR_NONE); idx = idx + 3'd1;
                    end else if (i_byte_req == CH_QUOTE) begin
                        ev[idx[1:0]] = mk(EV_OPEN, 8'd0, ERR_NONE); idx = idx + 3'd1;
                        n_mode = ST_STRING;
                    end else begin
                        ev[idx[1:0]] = mk(EV_OPEN, 8'd0, ERR_NONE);       idx = idx + 3'd1;
                        ev[idx[1:0]] = mk(EV_BYTE, i_byte_req, ERR_NONE); idx = idx + 3'd1;
                        n_mode = ST_BARE;
                    end
                end
            end
        end
    end

    always_comb begin
        o_bundle.cnt  = idx;
        o_bundle.ev   = ev;
        o_bundle.line = n_line;
        o_bundle.col  = n_col;
    end

    // Halted: take beats and drop them
    assign o_push = accept && (r_mode != ST_HALT) && (idx != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_SKIP;
            r_star <= 1'b0;
            r_line <= 16'd1;
            r_col  <= 16'd1;
            r_tab  <= TAB_RESET;
        end else begin
            if (i_cfg_we) r_tab <= i_cfg_data;
            if (accept && (r_mode != ST_HALT)) begin
                r_mode <= n_mode;
                r_star <= n_star;
                r_line <= n_line;
                r_col  <= n_col;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/cttk_fifo.sv */
// Bundle queue between the lexer front end and the event back end.
`default_nettype none

module cttk_fifo #(
    parameter int DEPTH = cttk_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire cttk_pkg::t_bundle   i_data,
    input  wire logic                i_pop,
    output      cttk_pkg::t_q_status o_status
);
    import cttk_pkg::*;

    // DEPTH must be at least 2
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            if (i_pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_comb begin
        o_status.empty = (r_cnt == '0);
        o_status.full  = (r_cnt == FULL_CNT);
        o_status.head  = r_mem[r_rd];
    end

endmodule

`default_nettype wire

/* rtl/cttk_back.sv */
// Back end: plays out the events of each bundle, one result beat per cycle while the output is not stalled.
`default_nettype none

module cttk_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cttk_pkg::t_q_status i_q,
    output      logic                o_pop,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      logic [2:0]          o_event_res,
    output      logic [7:0]          o_token_byte,
    output      logic [1:0]          o_error_code,
    output      logic [15:0]         o_line_number,
    output      logic [15:0]         o_column_number,
    output      logic                o_last
);
    import cttk_pkg::*;

    logic       r_busy;
    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       fire, done;
    t_evt       cur;

    assign cur   = r_bun.ev[r_idx];
    assign fire  = r_busy && !i_out_stall;
    assign done  = fire && o_last;
    assign o_pop = !i_q.empty && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_bun <= i_q.head;
    end

    assign o_out_valid     = r_busy;
    assign o_event_res     = cur.code;
    assign o_token_byte    = cur.tbyte;
    assign o_error_code    = cur.err;
    assign o_line_number   = r_bun.line;
    assign o_column_number = r_bun.col;
    assign o_last          = ({1'b0, r_idx} == (r_bun.cnt - 3'd1));

endmodule

`default_nettype wire
